### rtl/core/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
`default_nettype none
package wsfr_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LEN64    = 3'd1;
  localparam logic [2:0] ERR_FULL     = 3'd2;
  localparam logic [2:0] ERR_UNMASKED = 3'd3;
  localparam logic [2:0] ERR_OPCODE   = 3'd4;

  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_PONG  = 2'd1;
  localparam logic [1:0] REPLY_CLOSE = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_start;
  } in_word_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       message_done;
    logic [3:0] message_opcode;
    logic [7:0] message_length;
    logic [1:0] reply_kind;
    logic [7:0] reply_length;
    logic [2:0] error_code;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/wsfr_in_if.sv
// Input channel interface carrying received bytes.
`default_nettype none
interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       segment_start;

  modport source (output valid, data_byte, segment_start, input ready);
  modport sink (input valid, data_byte, segment_start, output ready);
endinterface
`default_nettype wire

### rtl/core/wsfr_out_if.sv
// Result channel interface carrying per-byte parse results.
`default_nettype none
interface wsfr_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       message_done;
  logic [3:0] message_opcode;
  logic [7:0] message_length;
  logic [1:0] reply_kind;
  logic [7:0] reply_length;
  logic [2:0] error_code;

  modport source (output valid, payload_valid, payload_byte, payload_index, message_done,
                  message_opcode, message_length, reply_kind, reply_length, error_code,
                  input ready);
  modport sink (input valid, payload_valid, payload_byte, payload_index, message_done,
                message_opcode, message_length, reply_kind, reply_length, error_code,
                output ready);
endinterface
`default_nettype wire

### rtl/core/wsfr_in_stage.sv
// Input register stage holding one accepted word until the parser takes it.
`default_nettype none
module wsfr_in_stage
  import wsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  input  wire logic     take,
  output logic          word_valid,
  output in_word_t      word
);

  logic     vld_r, vld_nxt;
  in_word_t word_r;

  assign in_ready   = !vld_r || take;
  assign word_valid = vld_r;
  assign word       = word_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule
`default_nettype wire

### rtl/core/wsfr_parse.sv
// Frame header parser, payload unmasking and message accounting for one word per cycle while step_en is high.
`default_nettype none
module wsfr_parse
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire in_word_t   word,
  input  wire logic [7:0] limit,
  output result_t         result
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        frame_final_r, frame_final_nxt;
  logic        frame_masked_r, frame_masked_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  mpos_r, mpos_nxt;
  logic [7:0]  stored_r, stored_nxt;

  phase_t      ph;
  logic        skip;
  logic        frame_end;
  logic [7:0]  b;
  logic [6:0]  len7;
  logic [3:0]  op;
  logic [7:0]  mask_byte;
  logic [2:0]  err;
  result_t     res;

  assign b = word.data_byte;

  always_comb begin
    unique case (mpos_r)
      2'd0:    mask_byte = key_r[31:24];
      2'd1:    mask_byte = key_r[23:16];
      2'd2:    mask_byte = key_r[15:8];
      default: mask_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    frame_final_nxt  = frame_final_r;
    frame_masked_nxt = frame_masked_r;
    kind_nxt         = kind_r;
    remain_nxt       = remain_r;
    key_nxt          = key_r;
    mpos_nxt         = mpos_r;
    stored_nxt       = stored_r;
    res              = '0;
    err              = ERR_NONE;
    frame_end        = 1'b0;
    skip             = 1'b0;
    len7             = b[6:0];
    op               = b[3:0];
    ph               = phase_r;

    if (phase_r == PH_DISCARD) begin
      if (!word.segment_start) begin
        skip = 1'b1;
      end else begin
        ph = PH_HDR0;
      end
    end

    if (!skip) begin
      unique case (ph)
        PH_HDR1: begin
          frame_masked_nxt = b[7];
          key_nxt          = '0;
          mpos_nxt         = '0;
          hdr_cnt_nxt      = '0;
          if (len7 == LEN_EXT64) begin
            err       = ERR_LEN64;
            phase_nxt = PH_DISCARD;
          end else begin
            if (!b[7]) begin
              err = ERR_UNMASKED;
            end
            if (len7 == LEN_EXT16) begin
              remain_nxt = '0;
              phase_nxt  = PH_EXT;
            end else begin
              remain_nxt = {9'd0, len7};
              if (b[7]) begin
                phase_nxt = PH_MASK;
              end else if (len7 == 7'd0) begin
                frame_end = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_EXT: begin
          remain_nxt = {remain_r[7:0], b};
          if (hdr_cnt_r != 2'd0) begin
            hdr_cnt_nxt = '0;
            if (frame_masked_r) begin
              phase_nxt = PH_MASK;
            end else if (remain_nxt == 16'd0) begin
              frame_end = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            hdr_cnt_nxt = 2'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], b};
          if (hdr_cnt_r == 2'd3) begin
            hdr_cnt_nxt = '0;
            if (remain_r == 16'd0) begin
              frame_end = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          mpos_nxt = mpos_r + 2'd1;
          if (stored_r < limit) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = b ^ mask_byte;
            res.payload_index = stored_r;
            stored_nxt        = stored_r + 8'd1;
          end else begin
            err = ERR_FULL;
          end
          remain_nxt = remain_r - 16'd1;
          if (remain_nxt == 16'd0) begin
            frame_end = 1'b1;
          end
        end
        default: begin
          frame_final_nxt = b[7];
          if (op != OP_CONT) begin
            kind_nxt   = op;
            stored_nxt = '0;
          end
          if (!(op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
                op == OP_CLOSE || op == OP_PING || op == OP_PONG)) begin
            err = ERR_OPCODE;
          end
          phase_nxt = PH_HDR1;
        end
      endcase

      if (frame_end) begin
        phase_nxt = PH_HDR0;
        if (frame_final_r) begin
          res.message_done   = 1'b1;
          res.message_opcode = kind_r;
          if (kind_r == OP_PING) begin
            res.reply_kind   = REPLY_PONG;
            res.reply_length = stored_nxt;
          end else if (kind_r == OP_CLOSE) begin
            res.reply_kind   = REPLY_CLOSE;
            res.reply_length = (stored_nxt >= 8'd2) ? 8'd2 : 8'd0;
          end
        end
      end
    end

    res.message_length = stored_nxt;
    res.error_code     = err;
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HDR0;
      hdr_cnt_r      <= '0;
      frame_final_r  <= 1'b0;
      frame_masked_r <= 1'b0;
      kind_r         <= '0;
      remain_r       <= '0;
      key_r          <= '0;
      mpos_r         <= '0;
      stored_r       <= '0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      hdr_cnt_r      <= hdr_cnt_nxt;
      frame_final_r  <= frame_final_nxt;
      frame_masked_r <= frame_masked_nxt;
      kind_r         <= kind_nxt;
      remain_r       <= remain_nxt;
      key_r          <= key_nxt;
      mpos_r         <= mpos_nxt;
      stored_r       <= stored_nxt;
    end
  end

  a_done_returns_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.message_done) |=> (phase_r == PH_HDR0))
    else $error("message completion did not return the parser to header parsing");

  a_store_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.payload_valid) |-> (res.payload_index < limit &&
                                        res.error_code == ERR_NONE))
    else $error("payload byte stored at or beyond the buffer limit");

  a_reply_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (res.reply_kind != REPLY_NONE) |-> res.message_done)
    else $error("echo request raised without a completed message");

  a_discard_after_len64: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.error_code == ERR_LEN64) |=> (phase_r == PH_DISCARD))
    else $error("64-bit length did not enter discard");

endmodule
`default_nettype wire

### rtl/core/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver with input and result registers.
// A word accepted into the input register is parsed and its result word held in the result register.
// Throughput: one word per cycle unless the result channel stalls; the header parse
// and unmask step is a single registered pass between the input and result registers.
// Reset: synchronous, active low; the parser waits for a first header byte and
// the buffer limit returns to its largest allowed value.
`default_nettype none
module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  wsfr_in_if.sink         in_chan,
  wsfr_out_if.source      out_chan,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  localparam int unsigned LIMIT_CAP   = (BUFFER_BYTES - 1 > 255) ? 255 : BUFFER_BYTES - 1;
  localparam logic [7:0]  LIMIT_CAP_B = 8'(LIMIT_CAP);

  logic [7:0] buf_limit_r, buf_limit_nxt;
  in_word_t   in_word;
  in_word_t   word;
  logic       word_valid;
  logic       advance;
  result_t    res;
  result_t    res_r;
  logic       out_vld_r, out_vld_nxt;

  assign in_word.data_byte     = in_chan.data_byte;
  assign in_word.segment_start = in_chan.segment_start;

  assign advance = word_valid && (!out_vld_r || out_chan.ready);

  always_comb begin
    buf_limit_nxt = buf_limit_r;
    if (cfg_wr_en) begin
      buf_limit_nxt = (cfg_wr_data > LIMIT_CAP_B) ? LIMIT_CAP_B : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_limit_r <= LIMIT_CAP_B;
    end else begin
      buf_limit_r <= buf_limit_nxt;
    end
  end

  wsfr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_word    (in_word),
    .take       (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  wsfr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .word    (word),
    .limit   (buf_limit_r),
    .result  (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.payload_valid  = res_r.payload_valid;
  assign out_chan.payload_byte   = res_r.payload_byte;
  assign out_chan.payload_index  = res_r.payload_index;
  assign out_chan.message_done   = res_r.message_done;
  assign out_chan.message_opcode = res_r.message_opcode;
  assign out_chan.message_length = res_r.message_length;
  assign out_chan.reply_kind     = res_r.reply_kind;
  assign out_chan.reply_length   = res_r.reply_length;
  assign out_chan.error_code     = res_r.error_code;

  a_limit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_limit_r <= LIMIT_CAP_B))
    else $error("buffer limit register exceeds the buffer capacity");

  a_advance_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("parsed word did not reach the result register");

  a_no_advance_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_chan.ready) |-> !advance)
    else $error("result register overwritten while its word was still pending");

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the WebSocket frame receiver with a byte-level frame predictor.
module tb_top;
  import wsfr_pkg::*;

  localparam int BUF_BYTES = 256;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BYTES = 370;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  wsfr_in_if in_bus ();
  wsfr_out_if out_bus ();

  websocket_frame_receiver #(.BUFFER_BYTES(BUF_BYTES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_bus),
    .out_chan(out_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  phase_t parse_ph = PH_HDR0;
  logic [1:0] hdr_count = '0;
  logic frame_fin = 1'b0;
  logic frame_has_mask = 1'b0;
  logic [3:0] msg_kind = '0;
  logic [15:0] bytes_left = '0;
  logic [31:0] mask_word = '0;
  logic [1:0] mask_pos = '0;
  logic [7:0] kept_count = '0;
  logic [7:0] limit_reg = 8'd255;

  result_t awaited_results[$];
  result_t want_r;
  int mismatches = 0;
  int bytes_sent = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic void finish_frame(inout result_t r);
    parse_ph = PH_HDR0;
    if (frame_fin) begin
      r.message_done = 1'b1;
      r.message_opcode = msg_kind;
      if (msg_kind == OP_PING) begin
        r.reply_kind = REPLY_PONG;
        r.reply_length = kept_count;
      end else if (msg_kind == OP_CLOSE) begin
        r.reply_kind = REPLY_CLOSE;
        r.reply_length = (kept_count >= 8'd2) ? 8'd2 : 8'd0;
      end
    end
  endfunction

  function automatic void open_payload(inout result_t r);
    if (bytes_left == 16'd0) begin
      finish_frame(r);
    end else begin
      parse_ph = PH_PAYLOAD;
    end
  endfunction

  function automatic void length_done(inout result_t r);
    hdr_count = '0;
    if (frame_has_mask) begin
      parse_ph = PH_MASK;
    end else begin
      open_payload(r);
    end
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b, input logic seg);
    result_t r;
    phase_t cur;
    logic [7:0] plain;
    int lim;
    r = '0;
    cur = parse_ph;
    if (cur == PH_DISCARD) begin
      if (!seg) begin
        r.message_length = kept_count;
        return r;
      end
      cur = PH_HDR0;
    end
    case (cur)
      PH_HDR1: begin
        frame_has_mask = b[7];
        mask_word = '0;
        mask_pos = '0;
        hdr_count = '0;
        if (b[6:0] == LEN_EXT64) begin
          r.error_code = ERR_LEN64;
          parse_ph = PH_DISCARD;
        end else begin
          if (!b[7]) r.error_code = ERR_UNMASKED;
          if (b[6:0] == LEN_EXT16) begin
            bytes_left = '0;
            parse_ph = PH_EXT;
          end else begin
            bytes_left = {9'd0, b[6:0]};
            length_done(r);
          end
        end
      end
      PH_EXT: begin
        bytes_left = {bytes_left[7:0], b};
        if (hdr_count >= 2'd1) begin
          length_done(r);
        end else begin
          hdr_count = 2'd1;
        end
      end
      PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        if (hdr_count == 2'd3) begin
          hdr_count = '0;
          open_payload(r);
        end else begin
          hdr_count++;
        end
      end
      PH_PAYLOAD: begin
        plain = b ^ mask_word[(3 - int'(mask_pos)) * 8 +: 8];
        lim = (int'(limit_reg) > BUF_BYTES - 1) ? BUF_BYTES - 1 : int'(limit_reg);
        mask_pos++;
        if (int'(kept_count) < lim) begin
          r.payload_valid = 1'b1;
          r.payload_byte = plain;
          r.payload_index = kept_count;
          kept_count++;
        end else begin
          r.error_code = ERR_FULL;
        end
        bytes_left--;
        if (bytes_left == 16'd0) finish_frame(r);
      end
      default: begin
        frame_fin = b[7];
        if (b[3:0] != OP_CONT) begin
          msg_kind = b[3:0];
          kept_count = '0;
        end
        case (b[3:0])
          OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: ;
          default: r.error_code = ERR_OPCODE;
        endcase
        parse_ph = PH_HDR1;
      end
    endcase
    r.message_length = kept_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 35);
      if (out_bus.valid && out_bus.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word arrived with none awaited");
          mismatches++;
        end else begin
          want_r = awaited_results.pop_front();
          check_field("payload_valid", want_r.payload_valid, out_bus.payload_valid);
          check_field("payload_byte", want_r.payload_byte, out_bus.payload_byte);
          check_field("payload_index", want_r.payload_index, out_bus.payload_index);
          check_field("message_done", want_r.message_done, out_bus.message_done);
          check_field("message_opcode", want_r.message_opcode, out_bus.message_opcode);
          check_field("message_length", want_r.message_length, out_bus.message_length);
          check_field("reply_kind", want_r.reply_kind, out_bus.reply_kind);
          check_field("reply_length", want_r.reply_length, out_bus.reply_length);
          check_field("error_code", want_r.error_code, out_bus.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic rand_seg();
    return $urandom_range(7) == 0;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic seg);
    while (!calm && $urandom_range(99) < 35) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.segment_start <= seg;
    do @(posedge clk); while (!in_bus.ready);
    awaited_results.push_back(deframe_byte(b, seg));
    bytes_sent++;
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input int len, input logic ext16);
    logic first_seg;
    first_seg = (parse_ph == PH_DISCARD) ? 1'b1 : rand_seg();
    send_word({fin, 3'($urandom_range(7)), op}, first_seg);
    send_word({masked, ext16 ? LEN_EXT16 : 7'(len)}, rand_seg());
    if (ext16) begin
      send_word(8'(len >> 8), rand_seg());
      send_word(8'(len), rand_seg());
    end
    if (masked) begin
      repeat (4) send_word(8'($urandom), rand_seg());
    end
    repeat (len) send_word(8'($urandom), rand_seg());
  endtask

  task automatic send_len64_frame(input int junk);
    logic first_seg;
    first_seg = (parse_ph == PH_DISCARD) ? 1'b1 : rand_seg();
    send_word(8'($urandom), first_seg);
    send_word({1'($urandom), LEN_EXT64}, rand_seg());
    repeat (junk) send_word(8'($urandom), 1'b0);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
  endtask

  task automatic test_directed_frames();
    send_frame(1'b1, OP_PING, 1'b1, 1, 1'b0);
    send_frame(1'b1, OP_CLOSE, 1'b0, 0, 1'b0);
    send_frame(1'b1, 4'hB, 1'b0, 0, 1'b0);
    send_frame(1'b0, OP_TEXT, 1'b0, 1, 1'b0);
    send_frame(1'b1, OP_CONT, 1'b0, 1, 1'b1);
    send_len64_frame(2);
    send_frame(1'b1, OP_PONG, 1'b0, 0, 1'b0);
  endtask

  task automatic test_buffer_limits();
    write_limit(8'd1);
    send_frame(1'b1, OP_CLOSE, 1'b1, 3, 1'b0);
    write_limit(8'd0);
    send_frame(1'b1, OP_PING, 1'b1, 2, 1'b0);
    write_limit(8'd2);
    send_frame(1'b1, OP_CLOSE, 1'b1, 2, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [3:0] known_ops[6];
    int p;
    int stop_at;
    int pick;
    int len_pick;
    int len;
    known_ops = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    for (p = 0; p < 4; p++) begin
      case (p)
        0: write_limit(8'd255);
        1: write_limit(8'd3);
        2: write_limit(8'($urandom_range(1, 254)));
        default: write_limit(8'd255);
      endcase
      calm = (p == 3);
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          len_pick = $urandom_range(99);
          if (len_pick < 70) begin
            len = $urandom_range(12);
          end else if (len_pick < 90) begin
            len = $urandom_range(13, 125);
          end else begin
            len = $urandom_range(300);
          end
          send_frame($urandom_range(99) < 70, known_ops[$urandom_range(5)], 1'b1, len,
                     len_pick >= 90);
        end else if (pick < 88) begin
          send_frame(1'($urandom), 4'($urandom), 1'b0, $urandom_range(10), 1'b0);
        end else if (pick < 94) begin
          send_frame(1'($urandom), $urandom_range(1) ? 4'($urandom_range(3, 7))
                     : 4'($urandom_range(11, 15)), 1'b1, $urandom_range(6), 1'b0);
        end else if (pick < 97) begin
          send_len64_frame($urandom_range(6));
        end else begin
          repeat ($urandom_range(1, 5)) send_word(8'($urandom), rand_seg());
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.segment_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_buffer_limits();
    test_random_traffic();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
